// File: rtl/core/avralu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avralu_pkg
// Shared types and constants for the 8-bit AVR-style ALU with status flags.
// ----------------------------------------------------------------------------
package avralu_pkg;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_ADC  = 3'd1,
        OP_AND  = 3'd2,
        OP_ASR  = 3'd3,
        OP_ADIW = 3'd4,
        OP_SBIW = 3'd5,
        OP_BCLR = 3'd6,
        OP_BLD  = 3'd7
    } t_opcode;

    // status register bit positions
    localparam logic [2:0] FLAG_C = 3'd0;
    localparam logic [2:0] FLAG_Z = 3'd1;
    localparam logic [2:0] FLAG_N = 3'd2;
    localparam logic [2:0] FLAG_V = 3'd3;
    localparam logic [2:0] FLAG_S = 3'd4;
    localparam logic [2:0] FLAG_H = 3'd5;
    localparam logic [2:0] FLAG_T = 3'd6;
    localparam logic [2:0] FLAG_I = 3'd7;

    localparam logic [7:0] STATUS_RESET = 8'h00;

    typedef struct packed {
        t_opcode     opcode;
        logic [15:0] operand_a;
        logic [7:0]  operand_b;
        logic [2:0]  bit_index;
    } t_alu_item;

endpackage

// File: rtl/core/avralu_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avralu_req_if
// Request channel: one operation with its operands per beat.
// ----------------------------------------------------------------------------
interface avralu_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [15:0] operand_a;
    logic [7:0]  operand_b;
    logic [2:0]  bit_index;

    modport source (
        output valid, opcode, operand_a, operand_b, bit_index,
        input  ready
    );
    modport sink (
        input  valid, opcode, operand_a, operand_b, bit_index,
        output ready
    );
endinterface

// File: rtl/core/avralu_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avralu_rsp_if
// Response channel: result value and new status per beat.
// ----------------------------------------------------------------------------
interface avralu_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] result;
    logic [7:0]  status_out;

    modport source (
        output valid, result, status_out,
        input  ready
    );
    modport sink (
        input  valid, result, status_out,
        output ready
    );
endinterface

// File: rtl/core/avralu_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avralu_exec
// Combinational datapath: computes the result and next status for one item.
// ----------------------------------------------------------------------------
module avralu_exec (
    input  avralu_pkg::t_alu_item i_item,
    input  logic [7:0]            i_status,
    output logic [15:0]           o_result,
    output logic [7:0]            o_status
);
    import avralu_pkg::*;

    logic [7:0]  a8;
    logic [7:0]  b8;
    logic [15:0] k16;
    logic        cin;
    logic [7:0]  add_r;
    logic        add_h;
    logic        add_c;
    logic        add_v;
    logic [7:0]  and_r;
    logic [7:0]  asr_r;
    logic [15:0] adiw_r;
    logic [15:0] sbiw_r;
    logic [7:0]  bld_r;
    logic        asr_v;
    logic        w_v;
    logic        w_c;

    assign a8  = i_item.operand_a[7:0];
    assign b8  = i_item.operand_b;
    assign k16 = {10'd0, i_item.operand_b[5:0]};
    assign cin = (i_item.opcode == OP_ADC) ? i_status[FLAG_C] : 1'b0;

    assign add_r = a8 + b8 + {7'd0, cin};
    assign add_h = (a8[3] & b8[3]) | (b8[3] & ~add_r[3]) | (~add_r[3] & a8[3]);
    assign add_c = (a8[7] & b8[7]) | (b8[7] & ~add_r[7]) | (~add_r[7] & a8[7]);
    assign add_v = (a8[7] & b8[7] & ~add_r[7]) | (~a8[7] & ~b8[7] & add_r[7]);

    assign and_r  = a8 & b8;
    assign asr_r  = {a8[7], a8[7:1]};
    assign asr_v  = asr_r[7] ^ a8[0];
    assign adiw_r = i_item.operand_a + k16;
    assign sbiw_r = i_item.operand_a - k16;

    always_comb begin
        bld_r = a8;
        bld_r[i_item.bit_index] = i_status[FLAG_T];
    end

    always_comb begin
        o_result = 16'd0;
        o_status = i_status;
        w_v      = 1'b0;
        w_c      = 1'b0;
        case (i_item.opcode)
            OP_ADD, OP_ADC: begin
                o_result       = {8'd0, add_r};
                o_status[FLAG_H] = add_h;
                o_status[FLAG_V] = add_v;
                o_status[FLAG_N] = add_r[7];
                o_status[FLAG_S] = add_r[7] ^ add_v;
                o_status[FLAG_Z] = (add_r == 8'd0);
                o_status[FLAG_C] = add_c;
            end
            OP_AND: begin
                o_result       = {8'd0, and_r};
                o_status[FLAG_V] = 1'b0;
                o_status[FLAG_N] = and_r[7];
                o_status[FLAG_S] = and_r[7];
                o_status[FLAG_Z] = (and_r == 8'd0);
            end
            OP_ASR: begin
                o_result       = {8'd0, asr_r};
                o_status[FLAG_C] = a8[0];
                o_status[FLAG_N] = asr_r[7];
                o_status[FLAG_V] = asr_v;
                o_status[FLAG_S] = asr_r[7] ^ asr_v;
                o_status[FLAG_Z] = (asr_r == 8'd0);
            end
            OP_ADIW: begin
                o_result       = adiw_r;
                w_v            = ~i_item.operand_a[15] & adiw_r[15];
                w_c            = ~adiw_r[15] & i_item.operand_a[15];
                o_status[FLAG_V] = w_v;
                o_status[FLAG_N] = adiw_r[15];
                o_status[FLAG_S] = adiw_r[15] ^ w_v;
                o_status[FLAG_Z] = (adiw_r == 16'd0);
                o_status[FLAG_C] = w_c;
            end
            OP_SBIW: begin
                o_result       = sbiw_r;
                w_v            = i_item.operand_a[15] & ~sbiw_r[15];
                w_c            = sbiw_r[15] & ~i_item.operand_a[15];
                o_status[FLAG_V] = w_v;
                o_status[FLAG_N] = sbiw_r[15];
                o_status[FLAG_S] = sbiw_r[15] ^ w_v;
                o_status[FLAG_Z] = (sbiw_r == 16'd0);
                o_status[FLAG_C] = w_c;
            end
            OP_BCLR: begin
                o_status[i_item.bit_index] = 1'b0;
            end
            OP_BLD: begin
                o_result = {8'd0, bld_r};
            end
            default: begin
                o_result = 16'd0;
            end
        endcase
    end

endmodule

// File: rtl/core/avr_alu_status_flags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avr_alu_status_flags
// 8-bit AVR-style ALU keeping the I,T,H,S,V,N,Z,C status register.
// ----------------------------------------------------------------------------
// Takes one operation per clock while not stalled (see below) and returns one
// result beat per operation, in order: the request lands in an input register,
// the datapath and the status update run from it, and the value with the new
// status sits in the result register. The
// status register is written in the same cycle the operation is evaluated,
// so back-to-back operations (e.g. ADD then ADC) see each other's flags with
// no bubble. Both stages stall when the result register holds a beat and the
// response side holds ready low. Status resets to all flags clear.
module avr_alu_status_flags (
    input  logic         i_clk,
    input  logic         i_rst_n,
    avralu_req_if.sink   i_req,
    avralu_rsp_if.source o_rsp
);
    import avralu_pkg::*;

    logic        r_in_valid;
    t_alu_item   r_in_item;
    logic        r_out_valid;
    logic [15:0] r_result;
    logic [7:0]  r_status_out;
    logic [7:0]  r_status;

    logic        n_out_valid;
    logic        n_in_valid;
    logic [15:0] n_result;
    logic [7:0]  n_status;
    logic        advance;
    logic        take_req;

    assign advance  = r_in_valid & (~r_out_valid | o_rsp.ready);
    // no beat is taken while reset is held
    assign i_req.ready = i_rst_n & (~r_in_valid | advance);
    assign take_req = i_req.valid & i_req.ready;

    assign n_in_valid  = take_req | (r_in_valid & ~advance);
    assign n_out_valid = advance | (r_out_valid & ~o_rsp.ready);

    avralu_exec u_exec (
        .i_item   (r_in_item),
        .i_status (r_status),
        .o_result (n_result),
        .o_status (n_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_status    <= STATUS_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_status <= n_status;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (take_req) begin
            r_in_item.opcode    <= t_opcode'(i_req.opcode);
            r_in_item.operand_a <= i_req.operand_a;
            r_in_item.operand_b <= i_req.operand_b;
            r_in_item.bit_index <= i_req.bit_index;
        end
        if (advance) begin
            r_result     <= n_result;
            r_status_out <= n_status;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.result     = r_result;
    assign o_rsp.status_out = r_status_out;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives operation beats into the AVR-style ALU and checks every result
// beat, value and status, against a cycle-free model of the flag logic.
// Directed corner cases come first, then random traffic with carry chains,
// under three idling profiles on the request and response channels.
// ----------------------------------------------------------------------------
module testbench;
    import avralu_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 8;
    localparam int PHASE_ITEMS  = 380;

    typedef struct packed {
        logic [15:0] result;
        logic [7:0]  status_out;
    } t_alu_beat;

    class alu_scoreboard;
        logic [7:0] sreg;
        t_alu_beat  pending_results[$];
        int         mismatches;

        function new();
            sreg       = STATUS_RESET;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function t_alu_beat exec_op(t_alu_item it);
            logic [7:0]  a8;
            logic [7:0]  b8;
            logic [7:0]  r8;
            logic [15:0] r16;
            logic [15:0] k16;
            logic        cin;
            logic        v;
            logic        c;
            t_alu_beat   beat;
            a8  = it.operand_a[7:0];
            b8  = it.operand_b;
            k16 = {10'd0, it.operand_b[5:0]};
            r16 = 16'd0;
            case (it.opcode)
                OP_ADD, OP_ADC: begin
                    cin = (it.opcode == OP_ADC) ? sreg[FLAG_C] : 1'b0;
                    r8  = a8 + b8 + {7'd0, cin};
                    sreg[FLAG_H] = (a8[3] & b8[3]) | (b8[3] & ~r8[3]) | (~r8[3] & a8[3]);
                    c = (a8[7] & b8[7]) | (b8[7] & ~r8[7]) | (~r8[7] & a8[7]);
                    v = (a8[7] & b8[7] & ~r8[7]) | (~a8[7] & ~b8[7] & r8[7]);
                    sreg[FLAG_V] = v;
                    sreg[FLAG_N] = r8[7];
                    sreg[FLAG_S] = r8[7] ^ v;
                    sreg[FLAG_Z] = (r8 == 8'd0);
                    sreg[FLAG_C] = c;
                    r16 = {8'd0, r8};
                end
                OP_AND: begin
                    r8 = a8 & b8;
                    sreg[FLAG_V] = 1'b0;
                    sreg[FLAG_N] = r8[7];
                    sreg[FLAG_S] = r8[7];
                    sreg[FLAG_Z] = (r8 == 8'd0);
                    r16 = {8'd0, r8};
                end
                OP_ASR: begin
                    r8 = {a8[7], a8[7:1]};
                    c  = a8[0];
                    v  = r8[7] ^ c;
                    sreg[FLAG_C] = c;
                    sreg[FLAG_N] = r8[7];
                    sreg[FLAG_V] = v;
                    sreg[FLAG_S] = r8[7] ^ v;
                    sreg[FLAG_Z] = (r8 == 8'd0);
                    r16 = {8'd0, r8};
                end
                OP_ADIW, OP_SBIW: begin
                    if (it.opcode == OP_ADIW) begin
                        r16 = it.operand_a + k16;
                        v   = ~it.operand_a[15] & r16[15];
                        c   = ~r16[15] & it.operand_a[15];
                    end else begin
                        r16 = it.operand_a - k16;
                        v   = it.operand_a[15] & ~r16[15];
                        c   = r16[15] & ~it.operand_a[15];
                    end
                    sreg[FLAG_V] = v;
                    sreg[FLAG_N] = r16[15];
                    sreg[FLAG_S] = r16[15] ^ v;
                    sreg[FLAG_Z] = (r16 == 16'd0);
                    sreg[FLAG_C] = c;
                end
                OP_BCLR: begin
                    sreg[it.bit_index] = 1'b0;
                    r16 = 16'd0;
                end
                default: begin
                    r8 = a8;
                    r8[it.bit_index] = sreg[FLAG_T];
                    r16 = {8'd0, r8};
                end
            endcase
            beat.result     = r16;
            beat.status_out = sreg;
            return beat;
        endfunction

        function void note_op(t_alu_item it);
            pending_results.push_back(exec_op(it));
        endfunction

        function void check_result(t_alu_beat got);
            t_alu_beat want;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing outstanding: result %h status %h",
                       got.result, got.status_out);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.result !== want.result) begin
                $error("result: expected %h, got %h", want.result, got.result);
                mismatches++;
            end
            if (got.status_out !== want.status_out) begin
                $error("status_out: expected %b, got %b", want.status_out, got.status_out);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    avralu_req_if req_if ();
    avralu_rsp_if rsp_if ();

    avr_alu_status_flags dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    alu_scoreboard sb;
    int            snd_idle_pct;
    int            rcv_idle_pct;
    int            quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // response side stalls at random, changed on the falling edge
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_if.ready = ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                sb.note_op('{opcode:    t_opcode'(req_if.opcode),
                             operand_a: req_if.operand_a,
                             operand_b: req_if.operand_b,
                             bit_index: req_if.bit_index});
            end
            if (rsp_if.valid && rsp_if.ready) begin
                sb.check_result('{result: rsp_if.result, status_out: rsp_if.status_out});
            end
        end
    end

    // counts cycles in which no beat moves on either side
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic idle_cycle();
        @(negedge i_clk);
        req_if.valid     = 1'b0;
        req_if.opcode    = 3'($urandom_range(0, 7));
        req_if.operand_a = 16'($urandom);
        req_if.operand_b = 8'($urandom);
        req_if.bit_index = 3'($urandom_range(0, 7));
    endtask

    task automatic send_op(t_alu_item it);
        while ($urandom_range(0, 99) < snd_idle_pct) idle_cycle();
        @(negedge i_clk);
        req_if.valid     = 1'b1;
        req_if.opcode    = it.opcode;
        req_if.operand_a = it.operand_a;
        req_if.operand_b = it.operand_b;
        req_if.bit_index = it.bit_index;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic send_fields(t_opcode op, logic [15:0] a, logic [7:0] b, logic [2:0] idx);
        send_op('{opcode: op, operand_a: a, operand_b: b, bit_index: idx});
    endtask

    // hold the request side off until every result beat is back
    task automatic drain();
        idle_cycle();
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_operand_a();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 6))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    2: return 16'h7FFF;
                    3: return 16'h8000;
                    4: return 16'h00FF;
                    5: return 16'h0080;
                    default: return 16'h007F;
                endcase
            end
            // near the word wrap and sign boundaries
            1: begin
                case ($urandom_range(0, 3))
                    0: return 16'h0000 | 16'($urandom_range(0, 63));
                    1: return 16'h7FC0 | 16'($urandom_range(0, 63));
                    2: return 16'h8000 | 16'($urandom_range(0, 63));
                    default: return 16'hFFC0 | 16'($urandom_range(0, 63));
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_operand_b();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h7F;
            3: return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic run_random(int n_items);
        int sent;
        int links;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 3) begin
                // multi-byte add: add then a run of adc on the carry
                links = $urandom_range(1, 3);
                send_fields(OP_ADD, pick_operand_a(), pick_operand_b(),
                            3'($urandom_range(0, 7)));
                repeat (links) send_fields(OP_ADC, pick_operand_a(), pick_operand_b(),
                                           3'($urandom_range(0, 7)));
                sent += links + 1;
            end else begin
                send_fields(t_opcode'($urandom_range(0, 7)), pick_operand_a(),
                            pick_operand_b(), 3'($urandom_range(0, 7)));
                sent++;
            end
            if ($urandom_range(0, 199) == 0) drain();
        end
    endtask

    task automatic run_directed();
        send_fields(OP_ADD,  16'h0000, 8'h00, 3'd0);
        send_fields(OP_ADD,  16'h00FF, 8'h01, 3'd7);
        send_fields(OP_ADC,  16'h0000, 8'h00, 3'd0);
        send_fields(OP_ADD,  16'h007F, 8'h01, 3'd0);
        send_fields(OP_ADD,  16'h0080, 8'h80, 3'd0);
        send_fields(OP_ADC,  16'hFF7F, 8'h7F, 3'd0);
        // upper byte of a is ignored by byte ops
        send_fields(OP_ADD,  16'hAB12, 8'h34, 3'd0);
        send_fields(OP_ADD,  16'h0008, 8'h08, 3'd0);
        // and keeps h and c from the add
        send_fields(OP_AND,  16'h00F0, 8'h0F, 3'd0);
        send_fields(OP_AND,  16'hFFFF, 8'h80, 3'd0);
        send_fields(OP_ASR,  16'h0081, 8'h00, 3'd0);
        send_fields(OP_ASR,  16'h0001, 8'h00, 3'd0);
        send_fields(OP_ASR,  16'hFF00, 8'hFF, 3'd0);
        send_fields(OP_ADIW, 16'hFFFF, 8'h3F, 3'd0);
        send_fields(OP_ADIW, 16'h7FFF, 8'h01, 3'd0);
        // top two bits of the word constant are ignored
        send_fields(OP_ADIW, 16'h1234, 8'hC1, 3'd0);
        send_fields(OP_SBIW, 16'h0000, 8'h01, 3'd0);
        send_fields(OP_SBIW, 16'h8000, 8'h01, 3'd0);
        send_fields(OP_SBIW, 16'h0001, 8'hC1, 3'd0);
        send_fields(OP_ADD,  16'h00FF, 8'hFF, 3'd0);
        send_fields(OP_BCLR, 16'hFFFF, 8'hFF, 3'd0);
        send_fields(OP_BCLR, 16'h0000, 8'h00, 3'd5);
        send_fields(OP_BCLR, 16'h0000, 8'h00, 3'd7);
        send_fields(OP_BLD,  16'hFFFF, 8'hFF, 3'd7);
        send_fields(OP_BLD,  16'h00FF, 8'h00, 3'd0);
    endtask

    initial begin
        sb               = new();
        snd_idle_pct     = 9;
        rcv_idle_pct     = 55;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.opcode    = OP_ADD;
        req_if.operand_a = 16'd0;
        req_if.operand_b = 8'd0;
        req_if.bit_index = 3'd0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        run_random(PHASE_ITEMS);
        drain();

        snd_idle_pct = 55;
        rcv_idle_pct = 9;
        run_random(PHASE_ITEMS);
        drain();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_random(PHASE_ITEMS);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
